FILE: sv/tsa_pkg.sv
`timescale 1ns / 1ps
package tsa_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] RK_UPDATE = 2'd0;
    localparam logic [1:0] RK_DROP   = 2'd1;
    localparam logic [1:0] RK_ACK    = 2'd2;
    localparam logic [1:0] RK_QUERY  = 2'd3;

    localparam int DIV_STEPS = 8;

    typedef struct packed {
        logic [7:0]  target;
        logic [15:0] owner;
        logic        kind;
        logic        curve;
        logic [15:0] from_v;
        logic [15:0] to_v;
        logic [31:0] begin_t;
        logic [15:0] len;
    } t_slot;

    typedef struct packed {
        logic load;
        logic rd;
        logic eval_a;
        logic eval_b;
        logic div;
        logic c1;
        logic c2;
        logic prd;
        logic emt;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic started;
    } t_stat;

    // byte kind clamps to 0..255, word kind keeps the low 16 bits
    function automatic logic [15:0] fit_kind(input logic signed [17:0] v, input logic kind);
        logic [15:0] res;
        res = v[15:0];
        if (kind) begin
            if (v < 0) begin
                res = 16'd0;
            end else if (v > 18'sd255) begin
                res = 16'd255;
            end
        end
        return res;
    endfunction

endpackage

FILE: sv/tsa_ctrl.sv
`timescale 1ns / 1ps
module tsa_ctrl #(
    parameter int SLOTS = 32,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tsa_pkg::t_stat i_stat,
    output tsa_pkg::t_cmd  o_cmd,
    output logic [IW-1:0] o_addr
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_EVA  = 4'd2;
    localparam logic [3:0] S_EVB  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_C1   = 4'd5;
    localparam logic [3:0] S_C2   = 4'd6;
    localparam logic [3:0] S_PRD  = 4'd7;
    localparam logic [3:0] S_EMT  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_phb, n_phb;
    logic [2:0]    r_cnt, n_cnt;
    logic          idx_last;

    assign idx_last = (r_idx == IW'(SLOTS - 1));
    assign busy     = (r_state != S_IDLE);
    assign o_addr   = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_phb   = r_phb;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_phb      = 1'b0;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = r_phb ? S_EVB : S_EVA;
            end
            S_EVA: begin
                o_cmd.eval_a = 1'b1;
                if (idx_last) begin
                    n_idx = '0;
                    if (i_stat.is_tick) begin
                        n_phb   = 1'b1;
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_EVB: begin
                o_cmd.eval_b = 1'b1;
                n_cnt        = '0;
                if (i_stat.started) begin
                    n_state = S_DIV;
                end else if (idx_last) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == 3'(tsa_pkg::DIV_STEPS - 1)) begin
                    n_state = S_C1;
                end
            end
            S_C1: begin
                o_cmd.c1 = 1'b1;
                n_state  = S_C2;
            end
            S_C2: begin
                o_cmd.c2 = 1'b1;
                n_state  = S_PRD;
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state   = S_EMT;
            end
            S_EMT: begin
                o_cmd.emt = 1'b1;
                if (idx_last) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_phb   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_phb   <= n_phb;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: sv/tsa_datapath.sv
`timescale 1ns / 1ps
module tsa_datapath #(
    parameter int SLOTS = 32,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsa_pkg::t_cmd      i_cmd,
    input  logic [IW-1:0]      i_addr,
    output tsa_pkg::t_stat     o_stat,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_current_time,
    input  logic [7:0]         i_target_id,
    input  logic [15:0]        i_owner_id,
    input  logic               i_value_kind,
    input  logic               i_ease_curve,
    input  logic signed [15:0] i_start_value,
    input  logic signed [15:0] i_end_value,
    input  logic [15:0]        i_delay,
    input  logic [15:0]        i_duration,
    output logic               o_strobe,
    output logic [1:0]         o_result_kind,
    output logic [7:0]         o_out_target,
    output logic signed [15:0] o_field_value,
    output logic               o_target_active,
    output logic               o_settling,
    output logic               o_last
);

    // latched item
    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic [7:0]  r_tgt;
    logic [15:0] r_own;
    logic        r_kind_in, r_curve_in;
    logic [15:0] r_from_in, r_to_in, r_delay, r_dur;

    tsa_pkg::t_slot r_mem [SLOTS];
    tsa_pkg::t_slot r_rd;
    tsa_pkg::t_slot wr_rec;
    logic [SLOTS-1:0] r_valid;

    logic          r_settle, r_act, r_found;
    logic [IW-1:0] r_free_idx;

    // step work registers
    logic               r_full, r_curve, r_kind;
    logic [15:0]        r_rem, r_len, r_from;
    logic [7:0]         r_q, r_tgt_w;
    logic signed [16:0] r_diff;
    logic [8:0]         r_t, r_inv;
    logic [17:0]        r_sq;
    logic [26:0]        r_cube;
    logic signed [26:0] r_prod;

    logic        r_pend;
    logic [7:0]  r_pt;
    logic [15:0] r_pv;

    logic        vld, run, cancel, keep, do_alloc, settle_fin;
    logic [31:0] endt, dlt, elapsed;
    logic [16:0] rem2;
    logic        ge;
    logic [8:0]  t9, inv9, k9;
    logic signed [18:0] vsum;
    logic [15:0] new_val;

    assign vld     = r_valid[i_addr];
    assign endt    = r_rd.begin_t + {16'd0, r_rd.len};
    assign dlt     = r_now - endt;
    assign run     = vld && dlt[31];
    assign elapsed = r_now - r_rd.begin_t;

    always_comb begin
        case (r_op)
            tsa_pkg::OP_START:  cancel = vld && (r_rd.target == r_tgt);
            tsa_pkg::OP_CANCEL: cancel = vld && (r_rd.owner == r_own);
            default:            cancel = 1'b0;
        endcase
    end
    assign keep = vld && !cancel;

    assign o_stat.is_tick = (r_op == tsa_pkg::OP_TICK);
    assign o_stat.started = vld && !elapsed[31];

    assign do_alloc   = i_cmd.fin && (r_op == tsa_pkg::OP_START) && r_found;
    // a new slot is running now unless delay and duration are both zero
    assign settle_fin = r_settle || ((r_op == tsa_pkg::OP_START) && r_found &&
                        (({1'b0, r_delay} + {1'b0, r_dur}) != 17'd0));

    assign rem2 = {r_rem, 1'b0};
    assign ge   = (rem2 >= {1'b0, r_len});
    assign t9   = r_full ? 9'd256 : {1'b0, r_q};
    assign inv9 = 9'd256 - t9;
    assign k9   = r_curve ? (9'd256 - r_cube[24:16]) : r_t;
    assign vsum = {{3{r_from[15]}}, r_from} + 19'(r_prod >>> 8);
    assign new_val = tsa_pkg::fit_kind(18'(vsum), r_kind);

    always_comb begin
        wr_rec.target  = r_tgt;
        wr_rec.owner   = r_own;
        wr_rec.kind    = r_kind_in;
        wr_rec.curve   = r_curve_in;
        wr_rec.from_v  = r_from_in;
        wr_rec.to_v    = r_to_in;
        wr_rec.begin_t = r_now + {16'd0, r_delay};
        wr_rec.len     = r_dur;
    end

    always_ff @(posedge i_clk) begin
        if (do_alloc) begin
            r_mem[r_free_idx] <= wr_rec;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_now      <= i_current_time;
            r_tgt      <= i_target_id;
            r_own      <= i_owner_id;
            r_kind_in  <= i_value_kind;
            r_curve_in <= i_ease_curve;
            r_from_in  <= i_start_value;
            r_to_in    <= i_end_value;
            r_delay    <= i_delay;
            r_dur      <= i_duration;
        end
        if (i_cmd.eval_a && !r_found && (r_op == tsa_pkg::OP_START) && !keep) begin
            r_free_idx <= i_addr;
        end
        if (i_cmd.eval_b) begin
            r_full  <= (r_rd.len == 16'd0) || (elapsed >= {16'd0, r_rd.len});
            r_rem   <= elapsed[15:0];
            r_q     <= '0;
            r_len   <= r_rd.len;
            r_from  <= r_rd.from_v;
            r_diff  <= $signed({r_rd.to_v[15], r_rd.to_v}) -
                       $signed({r_rd.from_v[15], r_rd.from_v});
            r_curve <= r_rd.curve;
            r_kind  <= r_rd.kind;
            r_tgt_w <= r_rd.target;
        end
        if (i_cmd.div) begin
            r_rem <= 16'(ge ? (rem2 - {1'b0, r_len}) : rem2);
            r_q   <= {r_q[6:0], ge};
        end
        if (i_cmd.c1) begin
            r_t   <= t9;
            r_inv <= inv9;
            r_sq  <= inv9 * inv9;
        end
        if (i_cmd.c2) begin
            r_cube <= r_sq * r_inv;
        end
        if (i_cmd.prd) begin
            r_prod <= r_diff * $signed({1'b0, k9});
        end
        if (i_cmd.emt) begin
            r_pt <= r_tgt_w;
            r_pv <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_settle <= 1'b0;
            r_act    <= 1'b0;
            r_found  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_settle <= 1'b0;
                r_act    <= 1'b0;
                r_found  <= 1'b0;
                r_pend   <= 1'b0;
            end
            if (i_cmd.eval_a) begin
                if (cancel) begin
                    r_valid[i_addr] <= 1'b0;
                end
                if ((r_op == tsa_pkg::OP_START) && !keep) begin
                    r_found <= 1'b1;
                end
                if (keep && run) begin
                    r_settle <= 1'b1;
                end
                if ((r_op == tsa_pkg::OP_QUERY) && run && (r_rd.target == r_tgt)) begin
                    r_act <= 1'b1;
                end
            end
            if (i_cmd.emt) begin
                r_pend <= 1'b1;
                if (r_full) begin
                    r_valid[i_addr] <= 1'b0;
                end
            end
            if (do_alloc) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (i_cmd.emt && r_pend) || i_cmd.fin;
        end
    end

    // one update is held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (i_cmd.emt) begin
            o_result_kind   <= tsa_pkg::RK_UPDATE;
            o_out_target    <= r_pt;
            o_field_value   <= r_pv;
            o_target_active <= 1'b0;
            o_settling      <= r_settle;
            o_last          <= 1'b0;
        end else if (i_cmd.fin) begin
            o_out_target    <= '0;
            o_field_value   <= '0;
            o_target_active <= 1'b0;
            o_settling      <= settle_fin;
            o_last          <= 1'b1;
            case (r_op)
                tsa_pkg::OP_START: begin
                    if (r_found) begin
                        o_result_kind <= tsa_pkg::RK_UPDATE;
                        o_out_target  <= r_tgt;
                        o_field_value <= tsa_pkg::fit_kind(
                            {{2{r_from_in[15]}}, r_from_in}, r_kind_in);
                    end else begin
                        o_result_kind <= tsa_pkg::RK_DROP;
                    end
                end
                tsa_pkg::OP_CANCEL: begin
                    o_result_kind <= tsa_pkg::RK_ACK;
                end
                tsa_pkg::OP_TICK: begin
                    if (r_pend) begin
                        o_result_kind <= tsa_pkg::RK_UPDATE;
                        o_out_target  <= r_pt;
                        o_field_value <= r_pv;
                    end else begin
                        o_result_kind <= tsa_pkg::RK_ACK;
                    end
                end
                default: begin
                    o_result_kind   <= tsa_pkg::RK_QUERY;
                    o_target_active <= r_act;
                end
            endcase
        end
    end

endmodule

FILE: sv/tween_slot_animator_unit.sv
`timescale 1ns / 1ps
// Animation slot pool. An item is taken when start is high and busy is low; results come
// out one per strobe cycle and must be taken as they appear, the last one marked by o_last.
// Every item first walks all SLOTS entries of the slot memory, reading and then evaluating
// each slot; start, cancel and query end after this walk. A tick then walks the slots again:
// an idle or pending slot is only read and checked, while a stepped one also runs an 8-step
// divider for the easing fraction plus two cube multiplies and the blend multiply.
module tween_slot_animator_unit #(
    parameter int SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_current_time,
    input  logic [7:0]         i_target_id,
    input  logic [15:0]        i_owner_id,
    input  logic               i_value_kind,
    input  logic               i_ease_curve,
    input  logic signed [15:0] i_start_value,
    input  logic signed [15:0] i_end_value,
    input  logic [15:0]        i_delay,
    input  logic [15:0]        i_duration,
    output logic               o_strobe,
    output logic [1:0]         o_result_kind,
    output logic [7:0]         o_out_target,
    output logic signed [15:0] o_field_value,
    output logic               o_target_active,
    output logic               o_settling,
    output logic               o_last
);

    localparam int IW = $clog2(SLOTS);

    tsa_pkg::t_cmd  cmd;
    tsa_pkg::t_stat stat;
    logic [IW-1:0]  addr;

    tsa_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_addr  (addr)
    );

    tsa_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_current_time  (i_current_time),
        .i_target_id     (i_target_id),
        .i_owner_id      (i_owner_id),
        .i_value_kind    (i_value_kind),
        .i_ease_curve    (i_ease_curve),
        .i_start_value   (i_start_value),
        .i_end_value     (i_end_value),
        .i_delay         (i_delay),
        .i_duration      (i_duration),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_out_target    (o_out_target),
        .o_field_value   (o_field_value),
        .o_target_active (o_target_active),
        .o_settling      (o_settling),
        .o_last          (o_last)
    );

endmodule

FILE: sv/tsa_checker.sv
`timescale 1ns / 1ps
module tsa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input logic [1:0]         o_result_kind,
    input logic [7:0]         o_out_target,
    input logic signed [15:0] o_field_value,
    input logic               o_target_active,
    input logic               o_last
);

    // an accepted item keeps the block busy until its walk is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after item accepted");

    // drop, ack and query answers are always the only result of their item
    a_single_kinds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result_kind != tsa_pkg::RK_UPDATE) |-> o_last)
        else $error("non-update result without last");

    a_active_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result_kind != tsa_pkg::RK_QUERY) |-> !o_target_active)
        else $error("target_active set outside query answer");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result_kind != tsa_pkg::RK_UPDATE) |->
            (o_out_target == 8'd0) && (o_field_value == 16'sd0))
        else $error("non-update result carries field data");

endmodule

bind tween_slot_animator_unit tsa_checker u_tsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_result_kind   (o_result_kind),
    .o_out_target    (o_out_target),
    .o_field_value   (o_field_value),
    .o_target_active (o_target_active),
    .o_last          (o_last)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tsa_pkg::*;

    localparam int NSLOT = 32;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] now;
        logic [7:0]  tgt;
        logic [15:0] own;
        logic        kind;
        logic        curve;
        logic [15:0] sv;
        logic [15:0] ev;
        logic [15:0] dly;
        logic [15:0] dur;
    } anim_req_t;

    typedef struct {
        logic [1:0]  rk;
        logic [7:0]  tgt;
        logic [15:0] val;
        logic        act;
        logic        settle;
        logic        last;
    } anim_out_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [31:0] i_current_time;
    logic [7:0]  i_target_id;
    logic [15:0] i_owner_id;
    logic        i_value_kind;
    logic        i_ease_curve;
    logic signed [15:0] i_start_value;
    logic signed [15:0] i_end_value;
    logic [15:0] i_delay;
    logic [15:0] i_duration;
    logic        o_strobe;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_out_target;
    logic signed [15:0] o_field_value;
    logic        o_target_active;
    logic        o_settling;
    logic        o_last;

    tween_slot_animator_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_current_time(i_current_time),
        .i_target_id(i_target_id), .i_owner_id(i_owner_id),
        .i_value_kind(i_value_kind), .i_ease_curve(i_ease_curve),
        .i_start_value(i_start_value), .i_end_value(i_end_value),
        .i_delay(i_delay), .i_duration(i_duration),
        .o_strobe(o_strobe), .o_result_kind(o_result_kind),
        .o_out_target(o_out_target), .o_field_value(o_field_value),
        .o_target_active(o_target_active), .o_settling(o_settling), .o_last(o_last)
    );

    // shadow slot pool
    logic        pv_valid [NSLOT];
    logic [7:0]  pv_tgt   [NSLOT];
    logic [15:0] pv_own   [NSLOT];
    logic        pv_kind  [NSLOT];
    logic        pv_curve [NSLOT];
    logic signed [15:0] pv_from [NSLOT];
    logic signed [15:0] pv_to   [NSLOT];
    logic [31:0] pv_begin [NSLOT];
    logic [15:0] pv_len   [NSLOT];

    anim_req_t pending_items[$];
    anim_out_t expected_updates[$];
    int        n_items_sent;
    int        n_results;
    int        n_mismatch;
    int        n_update_seen;
    int        n_drop_seen;
    logic      stim_done;

    function automatic logic [15:0] clamp_kind(input logic signed [31:0] v, input logic kind);
        logic [15:0] r;
        r = v[15:0];
        if (kind) begin
            if (v < 0) r = 16'd0;
            else if (v > 255) r = 16'd255;
        end
        return r;
    endfunction

    function automatic logic [31:0] ease_k(input logic [31:0] el, input logic [15:0] len,
                                           input logic curve);
        logic [31:0] t;
        logic [31:0] inv;
        if (len == 0 || el >= {16'd0, len}) return 32'd256;
        t = (el << 8) / len;
        if (!curve) return t;
        inv = 32'd256 - t;
        return 32'd256 - ((inv * inv * inv) >> 16);
    endfunction

    function automatic logic pool_settling(input logic [31:0] now);
        logic s;
        logic [31:0] d;
        s = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            d = now - (pv_begin[i] + {16'd0, pv_len[i]});
            if (pv_valid[i] && d[31]) s = 1'b1;
        end
        return s;
    endfunction

    task automatic predict_item(input anim_req_t it);
        anim_out_t outs[$];
        anim_out_t o;
        int fs;
        logic act;
        logic [31:0] el, k, mag, d;
        logic signed [31:0] diff, prod, v;
        logic s;
        fs = -1;
        o = '{rk: RK_ACK, tgt: 8'd0, val: 16'd0, act: 1'b0, settle: 1'b0, last: 1'b0};
        case (it.op)
            OP_START: begin
                for (int i = 0; i < NSLOT; i++)
                    if (pv_valid[i] && pv_tgt[i] == it.tgt) pv_valid[i] = 1'b0;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!pv_valid[i]) fs = i;
                if (fs < 0) begin
                    o.rk = RK_DROP;
                end else begin
                    pv_valid[fs] = 1'b1;
                    pv_tgt[fs] = it.tgt;
                    pv_own[fs] = it.own;
                    pv_kind[fs] = it.kind;
                    pv_curve[fs] = it.curve;
                    pv_from[fs] = it.sv;
                    pv_to[fs] = it.ev;
                    pv_begin[fs] = it.now + {16'd0, it.dly};
                    pv_len[fs] = it.dur;
                    o.rk = RK_UPDATE;
                    o.tgt = it.tgt;
                    o.val = clamp_kind(32'(signed'(it.sv)), it.kind);
                end
                outs.push_back(o);
            end
            OP_CANCEL: begin
                for (int i = 0; i < NSLOT; i++)
                    if (pv_valid[i] && pv_own[i] == it.own) pv_valid[i] = 1'b0;
                outs.push_back(o);
            end
            OP_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    el = it.now - pv_begin[i];
                    if (pv_valid[i] && !el[31]) begin
                        k = ease_k(el, pv_len[i], pv_curve[i]);
                        diff = 32'(pv_to[i]) - 32'(pv_from[i]);
                        prod = diff * signed'(k);
                        if (prod < 0) begin
                            mag = (32'(-prod) + 32'd255) >> 8;
                            v = 32'(pv_from[i]) - signed'(mag);
                        end else begin
                            v = 32'(pv_from[i]) + signed'(32'(prod) >> 8);
                        end
                        o.rk = RK_UPDATE;
                        o.tgt = pv_tgt[i];
                        o.val = clamp_kind(v, pv_kind[i]);
                        outs.push_back(o);
                        if (el >= {16'd0, pv_len[i]}) pv_valid[i] = 1'b0;
                    end
                end
                if (outs.size() == 0) begin
                    o.rk = RK_ACK;
                    o.tgt = 8'd0;
                    o.val = 16'd0;
                    outs.push_back(o);
                end
            end
            default: begin
                act = 1'b0;
                for (int i = 0; i < NSLOT; i++) begin
                    d = it.now - (pv_begin[i] + {16'd0, pv_len[i]});
                    if (pv_valid[i] && pv_tgt[i] == it.tgt && d[31]) act = 1'b1;
                end
                o.rk = RK_QUERY;
                o.act = act;
                outs.push_back(o);
            end
        endcase
        s = pool_settling(it.now);
        foreach (outs[j]) begin
            outs[j].settle = s;
            outs[j].last = (j == outs.size() - 1);
            expected_updates.push_back(outs[j]);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = 1'b1;
            #10 i_clk = 1'b0;
        end
    end

    // start only changes on falling edges, away from the rising edge that accepts it;
    // start is lowered on the falling edge after acceptance unless a new item follows
    logic taken;
    always @(posedge i_clk) taken <= i_rst_n && start && !busy;

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (start && !taken) begin
            // hold the item until taken
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_items.size() == 0) begin
            start <= 1'b0;
        end else begin
            anim_req_t it;
            it = pending_items.pop_front();
            predict_item(it);
            n_items_sent <= n_items_sent + 1;
            start <= 1'b1;
            i_opcode <= it.op;
            i_current_time <= it.now;
            i_target_id <= it.tgt;
            i_owner_id <= it.own;
            i_value_kind <= it.kind;
            i_ease_curve <= it.curve;
            i_start_value <= it.sv;
            i_end_value <= it.ev;
            i_delay <= it.dly;
            i_duration <= it.dur;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 8);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        anim_out_t e;
        if (i_rst_n && o_strobe) begin
            n_results <= n_results + 1;
            if (expected_updates.size() == 0) begin
                n_mismatch = n_mismatch + 1;
                if (n_mismatch <= 10) $display("unexpected result kind=%0d", o_result_kind);
            end else begin
                e = expected_updates.pop_front();
                if (o_result_kind == RK_UPDATE) n_update_seen <= n_update_seen + 1;
                if (o_result_kind == RK_DROP) n_drop_seen <= n_drop_seen + 1;
                if (o_result_kind !== e.rk || o_out_target !== e.tgt ||
                    o_field_value !== e.val || o_target_active !== e.act ||
                    o_settling !== e.settle || o_last !== e.last) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp k%0d t%0d v%0d a%0d s%0d l%0d got k%0d t%0d v%0d a%0d s%0d l%0d",
                            e.rk, e.tgt, $signed(e.val), e.act, e.settle, e.last,
                            o_result_kind, o_out_target, o_field_value, o_target_active,
                            o_settling, o_last);
                end
            end
        end
    end

    function automatic anim_req_t mk(input logic [1:0] op, input logic [31:0] now,
                                     input logic [7:0] tgt, input logic [15:0] own,
                                     input logic kind, input logic curve,
                                     input logic [15:0] sv, input logic [15:0] ev,
                                     input logic [15:0] dly, input logic [15:0] dur);
        anim_req_t r;
        r = '{op: op, now: now, tgt: tgt, own: own, kind: kind, curve: curve,
              sv: sv, ev: ev, dly: dly, dur: dur};
        return r;
    endfunction

    function automatic anim_req_t rand_item(input logic [31:0] now, input int tgt_span);
        anim_req_t r;
        int sel;
        sel = $urandom_range(0, 99);
        r = mk(OP_START, now, $urandom_range(0, tgt_span), $urandom_range(0, 7),
               $urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom,
               $urandom_range(0, 40), $urandom_range(0, 200));
        if ($urandom_range(0, 9) == 0) begin
            r.dly = $urandom;
            r.dur = $urandom;
            r.own = $urandom;
            r.tgt = $urandom;
        end
        if ($urandom_range(0, 4) == 0 && r.kind) begin
            r.sv = $urandom_range(0, 300) - 20;
            r.ev = $urandom_range(0, 300) - 20;
        end
        if (sel < 35) r.op = OP_START;
        else if (sel < 45) r.op = OP_CANCEL;
        else if (sel < 85) r.op = OP_TICK;
        else r.op = OP_QUERY;
        return r;
    endfunction

    initial begin
        logic [31:0] now;
        int spin;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_TICK;
        i_current_time = '0;
        i_target_id = '0;
        i_owner_id = '0;
        i_value_kind = 1'b0;
        i_ease_curve = 1'b0;
        i_start_value = '0;
        i_end_value = '0;
        i_delay = '0;
        i_duration = '0;
        n_items_sent = 0;
        n_results = 0;
        n_mismatch = 0;
        n_update_seen = 0;
        n_drop_seen = 0;
        stim_done = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            pv_valid[i] = 1'b0;
            pv_tgt[i] = '0;
            pv_own[i] = '0;
            pv_kind[i] = 1'b0;
            pv_curve[i] = 1'b0;
            pv_from[i] = '0;
            pv_to[i] = '0;
            pv_begin[i] = '0;
            pv_len[i] = '0;
        end

        // directed: empty tick, extremes, byte clamp, zero duration, delay pending
        pending_items.push_back(mk(OP_TICK, 32'd0, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_QUERY, 32'd0, 8'd5, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_START, 32'hFFFF_FFF0, 8'd255, 16'hFFFF, 1, 1,
                                   16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(mk(OP_START, 32'hFFFF_FFF0, 8'd1, 16'd1, 1, 0,
                                   16'h7FFF, 16'h8000, 16'd0, 16'd0));
        pending_items.push_back(mk(OP_START, 32'hFFFF_FFF0, 8'd2, 16'd1, 0, 1,
                                   16'h8000, 16'h7FFF, 16'd0, 16'd100));
        pending_items.push_back(mk(OP_START, 32'hFFFF_FFF0, 8'd3, 16'd2, 1, 0,
                                   16'd300, 16'hFFF0, 16'd20, 16'd50));
        pending_items.push_back(mk(OP_QUERY, 32'hFFFF_FFF8, 8'd3, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TICK, 32'hFFFF_FFF8, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TICK, 32'h0000_0030, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_START, 32'h0000_0030, 8'd2, 16'd7, 0, 0,
                                   16'd10, 16'd20, 16'd0, 16'd10));
        pending_items.push_back(mk(OP_CANCEL, 32'h0000_0030, 8'd0, 16'd2, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_CANCEL, 32'h0000_0030, 8'd0, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        // fill the pool then overflow it
        for (int i = 0; i < NSLOT + 1; i++)
            pending_items.push_back(mk(OP_START, 32'd100, 8'(10 + i), 16'(i & 3), i & 1,
                                       (i >> 1) & 1, 16'(i * 97), 16'(-i * 51), 16'd0,
                                       16'(i * 3)));
        pending_items.push_back(mk(OP_START, 32'd100, 8'd10, 16'd9, 0, 0, 1, 2, 0, 5));
        pending_items.push_back(mk(OP_TICK, 32'd150, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_TICK, 32'd400, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // random: time mostly advances a little, sometimes jumps or wraps
        now = 32'hFFFF_FF00;
        for (int i = 0; i < 410; i++) begin
            if ($urandom_range(0, 29) == 0) now = $urandom;
            else now = now + $urandom_range(0, 25);
            pending_items.push_back(rand_item(now, (i < 200) ? 15 : 63));
        end

        spin = 0;
        while ((pending_items.size() != 0 || start || expected_updates.size() != 0) &&
               spin < 2000000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (600) @(posedge i_clk);
        stim_done = 1'b1;
        $display("items sent %0d, results %0d, updates %0d, drops %0d",
                 n_items_sent, n_results, n_update_seen, n_drop_seen);
        if (n_mismatch == 0 && expected_updates.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("mismatches %0d, left over %0d", n_mismatch, expected_updates.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

endmodule
